/* hw/rtl/lfmcg_pkg.sv */
package lfmcg_pkg;

    localparam int PHASE_BITS = 32;
    localparam int TABLE_BITS = 10;
    localparam int INDEX_BITS = 16;

    localparam int TAB_SIZE     = 1 << TABLE_BITS;
    localparam int CORDIC_STEPS = 30;
    localparam longint CORDIC_GAIN_INV = 64'sd652032874;

    localparam int STEP_W  = 32;
    localparam int LEN_W   = 16;
    localparam int AMP_W   = 15;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [LEN_W-1:0] PRI_RESET = 16'hFFFF;
    localparam logic [AMP_W-1:0] AMP_RESET = 15'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHIRP_STEP   = 2'd0,
        REG_PULSE_LENGTH = 2'd1,
        REG_PRI_LENGTH   = 2'd2,
        REG_AMPLITUDE    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [STEP_W-1:0] chirp_step;
        logic [LEN_W-1:0]  pulse_length;
        logic [LEN_W-1:0]  pri_length;
        logic [AMP_W-1:0]  amplitude;
    } cfg_t;

    // one classified sample handed from front to back
    typedef struct packed {
        logic [TABLE_BITS-1:0] addr;
        logic                  in_pulse;
        logic                  last;
    } work_t;

    typedef logic signed [INDEX_BITS-1:0] sine_t;
    typedef sine_t sine_rom_t [TAB_SIZE];

    typedef longint arc_tab_t [CORDIC_STEPS];
    localparam arc_tab_t ARC_TAB = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680094, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1
    };

    // 30-step CORDIC sine on a 32-bit angle, result at 2^30 scale
    function automatic longint cordic_sine(input logic [31:0] angle);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint r;
        x = CORDIC_GAIN_INV;
        y = 0;
        z = longint'({34'd0, angle[29:0]});
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARC_TAB[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARC_TAB[i];
            end
        end
        case (angle[31:30])
            2'd0: r = y;
            2'd1: r = x;
            2'd2: r = -y;
            default: r = -x;
        endcase
        return r;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint lim;
        longint q;
        logic [31:0] angle;
        lim = (longint'(1) << (INDEX_BITS - 1)) - 1;
        for (int k = 0; k < TAB_SIZE; k++) begin
            angle = 32'(k) << (32 - TABLE_BITS);
            q = (cordic_sine(angle) + (longint'(1) << (30 - INDEX_BITS)))
                >>> (31 - INDEX_BITS);
            if (q > lim) q = lim;
            if (q < -lim) q = -lim;
            rom[k] = sine_t'(q);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* hw/rtl/lfmcg_front.sv */
module lfmcg_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lfmcg_pkg::cfg_t      cfg,
    input  logic                 accept,
    input  logic                 restart,
    output lfmcg_pkg::work_t     work
);

    logic [lfmcg_pkg::LEN_W-1:0]      index_reg, index_next;
    logic [lfmcg_pkg::PHASE_BITS-1:0] phase_reg, phase_next;
    logic [lfmcg_pkg::PHASE_BITS-1:0] freq_reg, freq_next;

    logic [lfmcg_pkg::LEN_W-1:0]      index_cur;
    logic [lfmcg_pkg::PHASE_BITS-1:0] phase_cur;
    logic [lfmcg_pkg::PHASE_BITS-1:0] freq_cur;
    logic [lfmcg_pkg::PHASE_BITS-1:0] step_ph;
    logic [lfmcg_pkg::LEN_W:0]        pri_eff;
    logic [lfmcg_pkg::LEN_W:0]        index_inc;

    assign step_ph = lfmcg_pkg::PHASE_BITS'(cfg.chirp_step);

    always_comb begin
        index_cur = restart ? '0 : index_reg;
        phase_cur = restart ? '0 : phase_reg;
        freq_cur  = restart ? (step_ph >> 1) : freq_reg;
        // zero interval length means a full 2^16 samples
        pri_eff   = (cfg.pri_length == '0) ? {1'b1, {lfmcg_pkg::LEN_W{1'b0}}}
                                           : {1'b0, cfg.pri_length};
        index_inc = {1'b0, index_cur} + 1'b1;

        work.addr     = phase_cur[lfmcg_pkg::PHASE_BITS-1 -: lfmcg_pkg::TABLE_BITS];
        work.in_pulse = (index_cur < cfg.pulse_length);
        work.last     = (index_inc >= pri_eff);

        if (work.last) begin
            index_next = '0;
            phase_next = '0;
            freq_next  = step_ph >> 1;
        end else begin
            index_next = index_inc[lfmcg_pkg::LEN_W-1:0];
            phase_next = phase_cur + freq_cur;
            freq_next  = freq_cur + step_ph;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
            phase_reg <= '0;
            freq_reg  <= '0;
        end else if (accept) begin
            index_reg <= index_next;
            phase_reg <= phase_next;
            freq_reg  <= freq_next;
        end
    end

    a_wrap_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && work.last |=> index_reg == '0 && phase_reg == '0)
        else $error("interval wrap did not reload state");

    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !work.last && !restart |=> index_reg == $past(index_reg) + 1'b1)
        else $error("sample index did not advance");

endmodule

/* hw/rtl/lfmcg_queue.sv */
module lfmcg_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  lfmcg_pkg::work_t     push_data,
    output logic                 full,
    input  logic                 pop,
    output lfmcg_pkg::work_t     pop_data,
    output logic                 empty
);

    lfmcg_pkg::work_t                entries [lfmcg_pkg::QUEUE_DEPTH];
    logic [lfmcg_pkg::QUEUE_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [lfmcg_pkg::QUEUE_AW:0]    count_reg, count_next;

    assign full     = (count_reg == (lfmcg_pkg::QUEUE_AW+1)'(lfmcg_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) entries[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (lfmcg_pkg::QUEUE_AW+1)'(lfmcg_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ptr_reg == rd_ptr_reg + count_reg[lfmcg_pkg::QUEUE_AW-1:0])
        else $error("queue pointers disagree with count");

endmodule

/* hw/rtl/lfmcg_back.sv */
module lfmcg_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [lfmcg_pkg::AMP_W-1:0]       amplitude,
    input  logic                              q_empty,
    input  lfmcg_pkg::work_t                  q_data,
    output logic                              q_pop,
    output logic signed [lfmcg_pkg::SAMPLE_W-1:0] sample_i,
    output logic signed [lfmcg_pkg::SAMPLE_W-1:0] sample_q,
    output logic                              in_pulse,
    output logic                              interval_end,
    output logic                              out_valid,
    input  logic                              out_ready
);

    localparam int PROD_W = lfmcg_pkg::INDEX_BITS + lfmcg_pkg::AMP_W + 1;
    localparam int SHIFT  = lfmcg_pkg::INDEX_BITS - 1;

    logic                              advance;
    logic [lfmcg_pkg::TABLE_BITS-1:0]  cos_addr;

    // stage 1: table read
    logic                   s1_valid_reg;
    lfmcg_pkg::sine_t       s1_cos_reg, s1_sin_reg;
    logic                   s1_pulse_reg, s1_last_reg;
    // stage 2: products
    logic                   s2_valid_reg;
    logic signed [PROD_W-1:0] s2_prod_i_reg, s2_prod_q_reg;
    logic                   s2_pulse_reg, s2_last_reg;
    // output register
    logic                   out_valid_reg;
    logic signed [lfmcg_pkg::SAMPLE_W-1:0] out_i_reg, out_q_reg;
    logic signed [lfmcg_pkg::SAMPLE_W-1:0] out_i_next, out_q_next;
    logic                   out_pulse_reg, out_last_reg;

    logic signed [PROD_W-1:0] amp_s;
    logic signed [PROD_W-1:0] trunc_i, trunc_q;

    assign advance  = !out_valid_reg || out_ready;
    assign q_pop    = advance && !q_empty;
    assign cos_addr = q_data.addr + lfmcg_pkg::TABLE_BITS'(lfmcg_pkg::TAB_SIZE / 4);
    assign amp_s    = PROD_W'(amplitude);

    // truncate toward zero: bias negatives before the arithmetic shift
    always_comb begin
        trunc_i = s2_prod_i_reg[PROD_W-1]
                ? (s2_prod_i_reg + PROD_W'((1 << SHIFT) - 1)) >>> SHIFT
                : s2_prod_i_reg >>> SHIFT;
        trunc_q = s2_prod_q_reg[PROD_W-1]
                ? (s2_prod_q_reg + PROD_W'((1 << SHIFT) - 1)) >>> SHIFT
                : s2_prod_q_reg >>> SHIFT;
        out_i_next = s2_pulse_reg ? trunc_i[lfmcg_pkg::SAMPLE_W-1:0] : '0;
        out_q_next = s2_pulse_reg ? trunc_q[lfmcg_pkg::SAMPLE_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_cos_reg    <= lfmcg_pkg::SINE_ROM[cos_addr];
            s1_sin_reg    <= lfmcg_pkg::SINE_ROM[q_data.addr];
            s1_pulse_reg  <= q_data.in_pulse;
            s1_last_reg   <= q_data.last;
            s2_prod_i_reg <= amp_s * PROD_W'(s1_cos_reg);
            s2_prod_q_reg <= amp_s * PROD_W'(s1_sin_reg);
            s2_pulse_reg  <= s1_pulse_reg;
            s2_last_reg   <= s1_last_reg;
            out_i_reg     <= out_i_next;
            out_q_reg     <= out_q_next;
            out_pulse_reg <= s2_pulse_reg;
            out_last_reg  <= s2_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign sample_i     = out_i_reg;
    assign sample_q     = out_q_reg;
    assign in_pulse     = out_pulse_reg;
    assign interval_end = out_last_reg;
    assign out_valid    = out_valid_reg;

    a_zero_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_pulse_reg |-> out_i_reg == '0 && out_q_reg == '0)
        else $error("nonzero sample outside pulse");

    // bubbles may carry unknown data, so compare with case equality
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> (s2_prod_i_reg === $past(s2_prod_i_reg))
                     && (s1_sin_reg === $past(s1_sin_reg)))
        else $error("pipeline moved during stall");

endmodule

/* hw/rtl/lfm_chirp_generator_unit.sv */
// Words pass the queue, table-read and product stages and output register. One word
// per cycle while not stalled; the phase/frequency update in the front end and the
// dual-read ROM/multiplier pipeline in the back end both run once per cycle. A 4-deep
// queue separates front and back, so input is taken while output stalls until it
// fills. Reset (aresetn low at a clock edge) clears registers to their defaults, state
// to sample zero, and empties the queue and the pipeline; no clearing pass is needed.
module lfm_chirp_generator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] sample_i, [31:16] sample_q
    output logic        m_tuser,    // [0] in_pulse
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [lfmcg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    lfmcg_pkg::cfg_t  cfg_reg;
    lfmcg_pkg::work_t work;
    lfmcg_pkg::work_t q_data;
    logic             q_full, q_empty, q_pop;
    logic             s_accept;
    logic signed [lfmcg_pkg::SAMPLE_W-1:0] sample_i, sample_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chirp_step   <= '0;
            cfg_reg.pulse_length <= '0;
            cfg_reg.pri_length   <= lfmcg_pkg::PRI_RESET;
            cfg_reg.amplitude    <= lfmcg_pkg::AMP_RESET;
        end else if (cfg_wr_en) begin
            case (lfmcg_pkg::cfg_reg_t'(cfg_index))
                lfmcg_pkg::REG_CHIRP_STEP:
                    cfg_reg.chirp_step <= cfg_data;
                lfmcg_pkg::REG_PULSE_LENGTH:
                    cfg_reg.pulse_length <= cfg_data[lfmcg_pkg::LEN_W-1:0];
                lfmcg_pkg::REG_PRI_LENGTH:
                    cfg_reg.pri_length <= cfg_data[lfmcg_pkg::LEN_W-1:0];
                lfmcg_pkg::REG_AMPLITUDE:
                    cfg_reg.amplitude <= cfg_data[lfmcg_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    lfmcg_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .accept  (s_accept),
        .restart (s_tdata[0]),
        .work    (work)
    );

    lfmcg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_data (work),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    lfmcg_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .amplitude    (cfg_reg.amplitude),
        .q_empty      (q_empty),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .sample_i     (sample_i),
        .sample_q     (sample_q),
        .in_pulse     (m_tuser),
        .interval_end (m_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready)
    );

    assign m_tdata = {sample_q, sample_i};

endmodule
